[hw/rtl/bed_pkg.sv]
// Shared types and constants for the bit extract / deposit unit.
// No dependencies; every other file of the unit refers to this package.
package bed_pkg;

   // Width of the data words on the item channels
   localparam int WORD_W = 64;

   // Operation select carried by each request item
   typedef enum logic {
      FUNC_EXTRACT = 1'b0,
      FUNC_DEPOSIT = 1'b1
   } func_type;

endpackage

[hw/rtl/bed_req_if.sv]
// Request channel of the bit extract / deposit unit: valid/ready plus payload.
// Depends on bed_pkg for the word width and the operation type.
interface bed_req_if;
   logic                        valid;
   logic                        ready;
   bed_pkg::func_type           func;
   logic [bed_pkg::WORD_W-1:0]  value;
   logic [bed_pkg::WORD_W-1:0]  select_mask;

   modport source (output valid, func, value, select_mask, input ready);
   modport sink   (input valid, func, value, select_mask, output ready);
endinterface

[hw/rtl/bed_rsp_if.sv]
// Response channel of the bit extract / deposit unit: valid/ready plus result.
// Depends on bed_pkg for the word width.
interface bed_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bed_pkg::WORD_W-1:0]  result;

   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);
endinterface

[hw/rtl/bed_prefix.sv]
// Two-stage parallel prefix count of clear mask bits below each position.
// Depends on bed_pkg for the operation type.
module bed_prefix #(
   parameter int LOG_WIDTH = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  bed_pkg::func_type             in_func,
   input  logic [(1 << LOG_WIDTH)-1:0]   in_value,
   input  logic [(1 << LOG_WIDTH)-1:0]   in_mask,
   output logic                          out_valid,
   input  logic                          out_ready,
   output bed_pkg::func_type             out_func,
   output logic [(1 << LOG_WIDTH)-1:0]   out_value,
   output logic [(1 << LOG_WIDTH)-1:0]   out_mask,
   output logic [LOG_WIDTH-1:0]          out_zcnt [1 << LOG_WIDTH]
);
   localparam int Width      = 1 << LOG_WIDTH;
   localparam int SplitLevel = LOG_WIDTH / 2;

   logic                  a_valid_ff;
   bed_pkg::func_type     a_func_ff;
   logic [Width-1:0]      a_value_ff;
   logic [Width-1:0]      a_mask_ff;
   logic [LOG_WIDTH-1:0]  a_zcnt_ff [Width];
   logic [LOG_WIDTH-1:0]  a_zcnt_in [Width];

   logic                  b_valid_ff;
   bed_pkg::func_type     b_func_ff;
   logic [Width-1:0]      b_value_ff;
   logic [Width-1:0]      b_mask_ff;
   logic [LOG_WIDTH-1:0]  b_zcnt_ff [Width];
   logic [LOG_WIDTH-1:0]  b_zcnt_in [Width];

   logic                  a_ready;
   logic                  b_ready;

   // Advance a stage when it is empty or the stage after it moves
   assign b_ready  = ~b_valid_ff | out_ready;
   assign a_ready  = ~a_valid_ff | b_ready;
   assign in_ready = a_ready;

   // Seed with the clear bit just below each position, then run the low levels
   always_comb begin
      a_zcnt_in[0] = '0;
      for (int i = 1; i < Width; i++) begin
         a_zcnt_in[i] = {{(LOG_WIDTH-1){1'b0}}, ~in_mask[i-1]};
      end
      for (int lvl = 0; lvl < SplitLevel; lvl++) begin
         for (int i = Width - 1; i >= (1 << lvl); i--) begin
            a_zcnt_in[i] = a_zcnt_in[i] + a_zcnt_in[i - (1 << lvl)];
         end
      end
   end

   // Finish the upper levels of the prefix sum
   always_comb begin
      b_zcnt_in = a_zcnt_ff;
      for (int lvl = SplitLevel; lvl < LOG_WIDTH; lvl++) begin
         for (int i = Width - 1; i >= (1 << lvl); i--) begin
            b_zcnt_in[i] = b_zcnt_in[i] + b_zcnt_in[i - (1 << lvl)];
         end
      end
   end

   // First stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_func_ff  <= in_func;
         a_value_ff <= in_value;
         a_mask_ff  <= in_mask;
         a_zcnt_ff  <= a_zcnt_in;
      end
   end

   // Second stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_func_ff  <= a_func_ff;
         b_value_ff <= a_value_ff;
         b_mask_ff  <= a_mask_ff;
         b_zcnt_ff  <= b_zcnt_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_func  = b_func_ff;
   assign out_value = b_value_ff;
   assign out_mask  = b_mask_ff;
   assign out_zcnt  = b_zcnt_ff;

   // Last position counts every clear mask bit below it
   a_zcnt_total: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> ($countones(~out_mask[Width-2:0]) == int'(out_zcnt[Width-1])))
      else $error("prefix count of clear mask bits is wrong");

endmodule

[hw/rtl/bed_compress.sv]
// Compress network: one register stage per shift distance, low distance first.
// Packs masked value bits downward and records each stage's routing for deposit.
// Depends on bed_pkg for the operation type.
module bed_compress #(
   parameter int LOG_WIDTH = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  bed_pkg::func_type             in_func,
   input  logic [(1 << LOG_WIDTH)-1:0]   in_value,
   input  logic [(1 << LOG_WIDTH)-1:0]   in_mask,
   input  logic [LOG_WIDTH-1:0]          in_zcnt [1 << LOG_WIDTH],
   output logic                          out_valid,
   input  logic                          out_ready,
   output bed_pkg::func_type             out_func,
   output logic [(1 << LOG_WIDTH)-1:0]   out_value,
   output logic [(1 << LOG_WIDTH)-1:0]   out_data,
   output logic [(1 << LOG_WIDTH)-1:0]   out_live,
   output logic [(1 << LOG_WIDTH)-1:0]   out_keep [LOG_WIDTH],
   output logic [(1 << LOG_WIDTH)-1:0]   out_move [LOG_WIDTH]
);
   localparam int Width = 1 << LOG_WIDTH;

   // Stage boundaries: index 0 is the module input, index s+1 is stage s output
   logic                  valid_w [LOG_WIDTH+1];
   logic                  ready_w [LOG_WIDTH+1];
   bed_pkg::func_type     func_w  [LOG_WIDTH+1];
   logic [Width-1:0]      value_w [LOG_WIDTH+1];
   logic [Width-1:0]      data_w  [LOG_WIDTH+1];
   logic [Width-1:0]      live_w  [LOG_WIDTH+1];
   logic [LOG_WIDTH-1:0]  shift_w [LOG_WIDTH+1][Width];
   logic [Width-1:0]      keep_w  [LOG_WIDTH+1][LOG_WIDTH];
   logic [Width-1:0]      move_w  [LOG_WIDTH+1][LOG_WIDTH];

   // Masked value bits enter at their own positions with their full shift
   assign valid_w[0] = in_valid;
   assign func_w[0]  = in_func;
   assign value_w[0] = in_value;
   assign data_w[0]  = in_value & in_mask;
   assign live_w[0]  = in_mask;
   assign shift_w[0] = in_zcnt;
   for (genvar e = 0; e < LOG_WIDTH; e++) begin : g_ctl_seed
      assign keep_w[0][e] = '0;
      assign move_w[0][e] = '0;
   end

   assign ready_w[LOG_WIDTH] = out_ready;
   assign in_ready           = ready_w[0];

   for (genvar s = 0; s < LOG_WIDTH; s++) begin : g_stage
      localparam int Dist = 1 << s;

      logic                  valid_ff;
      bed_pkg::func_type     func_ff;
      logic [Width-1:0]      value_ff;
      logic [Width-1:0]      data_ff;
      logic [Width-1:0]      data_in;
      logic [Width-1:0]      live_ff;
      logic [Width-1:0]      live_in;
      logic [LOG_WIDTH-1:0]  shift_ff [Width];
      logic [LOG_WIDTH-1:0]  shift_in [Width];
      logic [Width-1:0]      keep_ff  [LOG_WIDTH];
      logic [Width-1:0]      keep_in  [LOG_WIDTH];
      logic [Width-1:0]      move_ff  [LOG_WIDTH];
      logic [Width-1:0]      move_in  [LOG_WIDTH];
      logic [Width-1:0]      stay;
      logic [Width-1:0]      hop;

      // Split live bits into those that hop down by this distance and those that stay
      for (genvar j = 0; j < Width; j++) begin : g_split
         assign stay[j] = live_w[s][j] & ~shift_w[s][j][s];
         assign hop[j]  = live_w[s][j] &  shift_w[s][j][s];
      end

      // Gather each position from itself or from the one a distance above
      for (genvar j = 0; j < Width; j++) begin : g_route
         if (j + Dist < Width) begin : g_upper
            assign live_in[j]  = stay[j] | hop[j+Dist];
            assign data_in[j]  = (stay[j] & data_w[s][j]) | (hop[j+Dist] & data_w[s][j+Dist]);
            assign shift_in[j] = hop[j+Dist] ? shift_w[s][j+Dist] : shift_w[s][j];
         end else begin : g_top
            assign live_in[j]  = stay[j];
            assign data_in[j]  = stay[j] & data_w[s][j];
            assign shift_in[j] = shift_w[s][j];
         end
      end

      // Record this stage's routing for the deposit network
      always_comb begin
         keep_in    = keep_w[s];
         move_in    = move_w[s];
         keep_in[s] = stay;
         move_in[s] = hop;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (ready_w[s]) begin
            valid_ff <= valid_w[s];
         end
      end

      always_ff @(posedge clock) begin
         if (ready_w[s] && valid_w[s]) begin
            func_ff  <= func_w[s];
            value_ff <= value_w[s];
            data_ff  <= data_in;
            live_ff  <= live_in;
            shift_ff <= shift_in;
            keep_ff  <= keep_in;
            move_ff  <= move_in;
         end
      end

      // Advance when empty or when the next stage takes this one
      assign ready_w[s]   = ~valid_ff | ready_w[s+1];
      assign valid_w[s+1] = valid_ff;
      assign func_w[s+1]  = func_ff;
      assign value_w[s+1] = value_ff;
      assign data_w[s+1]  = data_ff;
      assign live_w[s+1]  = live_ff;
      assign shift_w[s+1] = shift_ff;
      assign keep_w[s+1]  = keep_ff;
      assign move_w[s+1]  = move_ff;
   end

   assign out_valid = valid_w[LOG_WIDTH];
   assign out_func  = func_w[LOG_WIDTH];
   assign out_value = value_w[LOG_WIDTH];
   assign out_data  = data_w[LOG_WIDTH];
   assign out_live  = live_w[LOG_WIDTH];
   assign out_keep  = keep_w[LOG_WIDTH];
   assign out_move  = move_w[LOG_WIDTH];

   // Packed bits must form a run from bit zero
   a_live_packed: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> ((out_live & (out_live + 1'b1)) == '0))
      else $error("compressed positions are not packed at the bottom");

   // Data bits never appear outside live positions
   a_data_in_live: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> ((out_data & ~out_live) == '0))
      else $error("compress data bit set at a dead position");

endmodule

[hw/rtl/bed_expand.sv]
// Expand network: replays the compress routing in reverse, high distance first.
// Scatters low value bits for deposit; passes extract results through.
// Depends on bed_pkg for the operation type.
module bed_expand #(
   parameter int LOG_WIDTH = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  bed_pkg::func_type             in_func,
   input  logic [(1 << LOG_WIDTH)-1:0]   in_value,
   input  logic [(1 << LOG_WIDTH)-1:0]   in_data,
   input  logic [(1 << LOG_WIDTH)-1:0]   in_live,
   input  logic [(1 << LOG_WIDTH)-1:0]   in_keep [LOG_WIDTH],
   input  logic [(1 << LOG_WIDTH)-1:0]   in_move [LOG_WIDTH],
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [(1 << LOG_WIDTH)-1:0]   out_data
);
   localparam int Width = 1 << LOG_WIDTH;

   logic                  valid_w [LOG_WIDTH+1];
   logic                  ready_w [LOG_WIDTH+1];
   bed_pkg::func_type     func_w  [LOG_WIDTH+1];
   logic [Width-1:0]      data_w  [LOG_WIDTH+1];
   logic [Width-1:0]      keep_w  [LOG_WIDTH+1][LOG_WIDTH];
   logic [Width-1:0]      move_w  [LOG_WIDTH+1][LOG_WIDTH];

   // Deposit starts from the low value bits, one per set mask bit
   assign valid_w[0] = in_valid;
   assign func_w[0]  = in_func;
   assign data_w[0]  = (in_func == bed_pkg::FUNC_DEPOSIT) ? (in_value & in_live) : in_data;
   assign keep_w[0]  = in_keep;
   assign move_w[0]  = in_move;

   assign ready_w[LOG_WIDTH] = out_ready;
   assign in_ready           = ready_w[0];

   for (genvar k = 0; k < LOG_WIDTH; k++) begin : g_stage
      localparam int Lvl  = LOG_WIDTH - 1 - k;
      localparam int Dist = 1 << Lvl;

      logic               valid_ff;
      bed_pkg::func_type  func_ff;
      logic [Width-1:0]   data_ff;
      logic [Width-1:0]   data_in;
      logic [Width-1:0]   keep_ff [LOG_WIDTH];
      logic [Width-1:0]   move_ff [LOG_WIDTH];
      logic [Width-1:0]   spread;

      // Undo one compress stage: bits that hopped down move back up
      for (genvar j = 0; j < Width; j++) begin : g_route
         if (j >= Dist) begin : g_lower
            assign spread[j] = (keep_w[k][Lvl][j] & data_w[k][j])
                             | (move_w[k][Lvl][j] & data_w[k][j-Dist]);
         end else begin : g_bottom
            assign spread[j] = keep_w[k][Lvl][j] & data_w[k][j];
         end
      end

      assign data_in = (func_w[k] == bed_pkg::FUNC_DEPOSIT) ? spread : data_w[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (ready_w[k]) begin
            valid_ff <= valid_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ready_w[k] && valid_w[k]) begin
            func_ff <= func_w[k];
            data_ff <= data_in;
            keep_ff <= keep_w[k];
            move_ff <= move_w[k];
         end
      end

      // Advance when empty or when the next stage takes this one
      assign ready_w[k]   = ~valid_ff | ready_w[k+1];
      assign valid_w[k+1] = valid_ff;
      assign func_w[k+1]  = func_ff;
      assign data_w[k+1]  = data_ff;
      assign keep_w[k+1]  = keep_ff;
      assign move_w[k+1]  = move_ff;
   end

   assign out_valid = valid_w[LOG_WIDTH];
   assign out_data  = data_w[LOG_WIDTH];

endmodule

[hw/rtl/bit_extract_deposit_unit.sv]
// Throughput: one item per cycle unless the response stalls; the two prefix-count
// stages and the two LOG_WIDTH-deep shift networks are all register stages.
// A stalled response holds every full stage behind it; empty stages still take items.
// Reset (synchronous) clears every stage valid flag; data registers are not reset.
module bit_extract_deposit_unit #(
   parameter int LOG_WIDTH = 6
) (
   input  logic          clock,
   input  logic          reset,
   bed_req_if.sink       req_ch,
   bed_rsp_if.source     rsp_ch
);
   localparam int Width     = 1 << LOG_WIDTH;
   localparam int WordWidth = bed_pkg::WORD_W;

   logic                  pre_valid;
   logic                  pre_ready;
   bed_pkg::func_type     pre_func;
   logic [Width-1:0]      pre_value;
   logic [Width-1:0]      pre_mask;
   logic [LOG_WIDTH-1:0]  pre_zcnt [Width];

   logic                  cmp_valid;
   logic                  cmp_ready;
   bed_pkg::func_type     cmp_func;
   logic [Width-1:0]      cmp_value;
   logic [Width-1:0]      cmp_data;
   logic [Width-1:0]      cmp_live;
   logic [Width-1:0]      cmp_keep [LOG_WIDTH];
   logic [Width-1:0]      cmp_move [LOG_WIDTH];

   logic [Width-1:0]      exp_data;

   // Count clear mask bits below every position
   bed_prefix #(.LOG_WIDTH(LOG_WIDTH)) u_prefix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_func   (req_ch.func),
      .in_value  (req_ch.value[Width-1:0]),
      .in_mask   (req_ch.select_mask[Width-1:0]),
      .out_valid (pre_valid),
      .out_ready (pre_ready),
      .out_func  (pre_func),
      .out_value (pre_value),
      .out_mask  (pre_mask),
      .out_zcnt  (pre_zcnt)
   );

   // Pack selected bits downward and record the routing
   bed_compress #(.LOG_WIDTH(LOG_WIDTH)) u_compress (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pre_valid),
      .in_ready  (pre_ready),
      .in_func   (pre_func),
      .in_value  (pre_value),
      .in_mask   (pre_mask),
      .in_zcnt   (pre_zcnt),
      .out_valid (cmp_valid),
      .out_ready (cmp_ready),
      .out_func  (cmp_func),
      .out_value (cmp_value),
      .out_data  (cmp_data),
      .out_live  (cmp_live),
      .out_keep  (cmp_keep),
      .out_move  (cmp_move)
   );

   // Replay the routing upward for deposit
   bed_expand #(.LOG_WIDTH(LOG_WIDTH)) u_expand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmp_valid),
      .in_ready  (cmp_ready),
      .in_func   (cmp_func),
      .in_value  (cmp_value),
      .in_data   (cmp_data),
      .in_live   (cmp_live),
      .in_keep   (cmp_keep),
      .in_move   (cmp_move),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (exp_data)
   );

   // Zero the result bits above the working width
   assign rsp_ch.result = WordWidth'(exp_data);

   // No response may be offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid directly after reset");

endmodule
